@@ hw/rtl/expiry_claim_extract_and_check_top_assert.svh @@
// Assertion macros for the expiry claim block.
`ifndef EXPIRY_CLAIM_EXTRACT_AND_CHECK_TOP_ASSERT_SVH
`define EXPIRY_CLAIM_EXTRACT_AND_CHECK_TOP_ASSERT_SVH

`ifndef SYNTH
`define ECC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecc check failed");
`define ECC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecc check failed");
`else
`define ECC_ASSERT_NOW(label, ante, cons)
`define ECC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/ecc_pkg.sv @@
`default_nettype none

package ecc_pkg;

  localparam int unsigned TIME_W = 64;

  localparam logic [2:0] KEY_LEN = 3'd6;
  localparam logic [2:0] KEY_E_POS = 3'd5;
  localparam logic [2:0] KEY_AFTER_E = 3'd2;
  localparam logic [2:0] KEY_AFTER_QUOTE = 3'd1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_P = 8'h70;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NO_KEY    = 2'd1,
    STATUS_NO_DIGITS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PHASE_SEARCH = 2'd0,
    PHASE_SKIP   = 2'd1,
    PHASE_DIGITS = 2'd2,
    PHASE_DONE   = 2'd3
  } phase_t;

  function automatic logic [7:0] key_at(input logic [2:0] idx);
    logic [7:0] k;
    case (idx)
      3'd0: k = CH_QUOTE;
      3'd1: k = CH_E;
      3'd2: k = CH_X;
      3'd3: k = CH_P;
      3'd4: k = CH_QUOTE;
      3'd5: k = CH_COLON;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ecc_if.sv @@
`default_nettype none

interface ecc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ecc_out_if;
  logic                          valid;
  logic                          ready;
  ecc_pkg::status_t              status;
  logic [ecc_pkg::TIME_W-1:0]    expiry_value;
  logic                          expired;

  modport source (output valid, output status, output expiry_value, output expired,
                  input ready);
  modport sink (input valid, input status, input expiry_value, input expired,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/expiry_claim_extract_and_check_top.sv @@
// Latency: a result is valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; input stalls only while a result waits
// untaken in the result register.
// Synchronous active-low reset clears the key matcher, parser, result valid
// and current_time (to 0).
`default_nettype none

module expiry_claim_extract_and_check_top (
  input  wire                         clk,
  input  wire                         rst_n,
  ecc_in_if.sink                      in_ch,
  ecc_out_if.source                   out_ch,
  input  wire                         cfg_wr_en,
  input  wire [ecc_pkg::TIME_W-1:0]   cfg_wr_data
);
  import ecc_pkg::*;

  logic [TIME_W-1:0] cur_time_r;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        match_r, match_nxt;
  logic [TIME_W-1:0] value_r, value_nxt;
  logic              seen_r, seen_nxt;

  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [TIME_W-1:0] expiry_r, expiry_nxt;
  logic              expired_r, expired_nxt;

  logic              in_ready;
  logic              in_fire;
  logic [7:0]        b;
  logic              is_digit;
  logic              is_blank;
  logic [TIME_W-1:0] value_acc;

  assign in_ready = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ready;
  assign b        = in_ch.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_blank = (b == CH_SPACE) || (b == CH_TAB);
  assign value_acc = (value_r << 3) + (value_r << 1) + {{(TIME_W-4){1'b0}}, b[3:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_time_r <= '0;
    end else if (cfg_wr_en) begin
      cur_time_r <= cfg_wr_data;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    value_nxt = value_r;
    seen_nxt  = seen_r;
    case (phase_r)
      PHASE_SEARCH: begin
        if (match_r < KEY_LEN && b == key_at(match_r)) begin
          match_nxt = match_r + 3'd1;
        end else if (match_r == KEY_E_POS && b == CH_E) begin
          match_nxt = KEY_AFTER_E;
        end else if (b == CH_QUOTE) begin
          match_nxt = KEY_AFTER_QUOTE;
        end else begin
          match_nxt = '0;
        end
        if (match_nxt == KEY_LEN) begin
          phase_nxt = PHASE_SKIP;
        end
      end
      PHASE_SKIP: begin
        if (is_blank) begin
          phase_nxt = PHASE_SKIP;
        end else if (is_digit) begin
          value_nxt = value_acc;
          seen_nxt  = 1'b1;
          phase_nxt = PHASE_DIGITS;
        end else begin
          phase_nxt = PHASE_DONE;
        end
      end
      PHASE_DIGITS: begin
        if (is_digit) begin
          value_nxt = value_acc;
          seen_nxt  = 1'b1;
        end else begin
          phase_nxt = PHASE_DONE;
        end
      end
      default: begin
        phase_nxt = PHASE_DONE;
      end
    endcase

    expiry_nxt  = '0;
    expired_nxt = 1'b0;
    if (phase_nxt == PHASE_SEARCH) begin
      status_nxt = STATUS_NO_KEY;
    end else if (!seen_nxt) begin
      status_nxt = STATUS_NO_DIGITS;
    end else begin
      status_nxt  = STATUS_FOUND;
      expiry_nxt  = value_nxt;
      expired_nxt = (cur_time_r >= value_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_SEARCH;
      match_r <= '0;
      value_r <= '0;
      seen_r  <= 1'b0;
    end else if (in_fire) begin
      if (in_ch.last_byte) begin
        phase_r <= PHASE_SEARCH;
        match_r <= '0;
        value_r <= '0;
        seen_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        match_r <= match_nxt;
        value_r <= value_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.last_byte) begin
      status_r  <= status_nxt;
      expiry_r  <= expiry_nxt;
      expired_r <= expired_nxt;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.expiry_value = expiry_r;
  assign out_ch.expired      = expired_r;

`include "expiry_claim_extract_and_check_top_assert.svh"

  `ECC_ASSERT_NEXT(a_last_clears, in_fire && in_ch.last_byte, phase_r == PHASE_SEARCH && match_r == 3'd0 && !seen_r && value_r == '0)
  `ECC_ASSERT_NOW(a_search_range, phase_r == PHASE_SEARCH, match_r < KEY_LEN)
  `ECC_ASSERT_NOW(a_seen_phase, seen_r, phase_r == PHASE_DIGITS || phase_r == PHASE_DONE)
  `ECC_ASSERT_NOW(a_full_blocks, out_valid_r && !out_ch.ready, !in_ready)
  `ECC_ASSERT_NOW(a_value_found_only, out_valid_r && status_r != STATUS_FOUND, expiry_r == '0 && !expired_r)

endmodule

`default_nettype wire
